/* sv/vcw_pkg.sv */
// ----------------------------------------------------------------------------
// vcw_pkg: shared types and constants for the velocity command watchdog
// Event codes, register indexes, payload structs and reset values.
// ----------------------------------------------------------------------------
package vcw_pkg;

  // Default widths of the internal velocity and age registers
  localparam int VEL_WIDTH_DEF = 16;
  localparam int AGE_WIDTH_DEF = 16;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TIMEOUT_W   = 16;
  localparam int LIMIT_W     = 15;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CMD_TIMEOUT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOC_TIMEOUT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_VX    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_VY    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_WZ    = 3'd4;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] CMD_TIMEOUT_RST = 16'd500;
  localparam logic [TIMEOUT_W-1:0] LOC_TIMEOUT_RST = 16'd750;
  localparam logic [LIMIT_W-1:0]   LIMIT_VX_RST    = 15'd819;
  localparam logic [LIMIT_W-1:0]   LIMIT_VY_RST    = 15'd0;
  localparam logic [LIMIT_W-1:0]   LIMIT_WZ_RST    = 15'd1229;

  // Event codes carried in the request
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CMD     = 2'd1,
    MODE_LOC     = 2'd2,
    MODE_PUBLISH = 2'd3
  } mode_t;

  // Q4.12 velocity field as it appears on the ports
  typedef logic signed [15:0] vel_t;

  typedef struct packed {
    mode_t mode;
    vel_t  lin_x;
    vel_t  lin_y;
    vel_t  ang_z;
    logic  cmd_invalid;
    logic  loc_ok;
  } req_t;

  typedef struct packed {
    vel_t out_vx;
    vel_t out_vy;
    vel_t out_wz;
    logic is_safe;
  } rsp_t;

  // Configuration register set
  typedef struct packed {
    logic [TIMEOUT_W-1:0] cmd_timeout_ticks;
    logic [TIMEOUT_W-1:0] loc_timeout_ticks;
    logic [LIMIT_W-1:0]   limit_vx;
    logic [LIMIT_W-1:0]   limit_vy;
    logic [LIMIT_W-1:0]   limit_wz;
  } cfg_t;

  // Presence and health flags of the held command and localization status
  typedef struct packed {
    logic command_present;
    logic status_present;
    logic status_good;
  } flags_t;

endpackage

/* sv/vcw_cfg.sv */
// ----------------------------------------------------------------------------
// vcw_cfg: configuration register file
// Holds timeouts and axis limits; written through a valid/ready port.
// ----------------------------------------------------------------------------
module vcw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vcw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output vcw_pkg::cfg_t                     regs
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.cmd_timeout_ticks <= vcw_pkg::CMD_TIMEOUT_RST;
      regs.loc_timeout_ticks <= vcw_pkg::LOC_TIMEOUT_RST;
      regs.limit_vx          <= vcw_pkg::LIMIT_VX_RST;
      regs.limit_vy          <= vcw_pkg::LIMIT_VY_RST;
      regs.limit_wz          <= vcw_pkg::LIMIT_WZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vcw_pkg::REG_CMD_TIMEOUT: regs.cmd_timeout_ticks <= cfg_data;
        vcw_pkg::REG_LOC_TIMEOUT: regs.loc_timeout_ticks <= cfg_data;
        vcw_pkg::REG_LIMIT_VX:    regs.limit_vx <= cfg_data[vcw_pkg::LIMIT_W-1:0];
        vcw_pkg::REG_LIMIT_VY:    regs.limit_vy <= cfg_data[vcw_pkg::LIMIT_W-1:0];
        vcw_pkg::REG_LIMIT_WZ:    regs.limit_wz <= cfg_data[vcw_pkg::LIMIT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

/* sv/vcw_state.sv */
// ----------------------------------------------------------------------------
// vcw_state: watchdog state registers
// Held command, ages and presence flags, updated by one event per cycle while step is high.
// ----------------------------------------------------------------------------
module vcw_state #(
  parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF,
  parameter int AGE_WIDTH = vcw_pkg::AGE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  vcw_pkg::req_t               item,
  output logic signed [VEL_WIDTH-1:0] held_vx,
  output logic signed [VEL_WIDTH-1:0] held_vy,
  output logic signed [VEL_WIDTH-1:0] held_wz,
  output logic [AGE_WIDTH-1:0]        command_age,
  output logic [AGE_WIDTH-1:0]        status_age,
  output vcw_pkg::flags_t             flags
);

  logic [AGE_WIDTH-1:0] command_age_inc;
  logic [AGE_WIDTH-1:0] status_age_inc;

  // Saturating age increments
  assign command_age_inc = (&command_age) ? command_age : command_age + 1'b1;
  assign status_age_inc  = (&status_age)  ? status_age  : status_age + 1'b1;

  // Ages and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      command_age <= '0;
      status_age  <= '0;
      flags       <= '0;
    end else if (step) begin
      case (item.mode)
        vcw_pkg::MODE_TICK: begin
          command_age <= command_age_inc;
          status_age  <= status_age_inc;
        end
        vcw_pkg::MODE_CMD: begin
          if (item.cmd_invalid) begin
            flags.command_present <= 1'b0;
          end else begin
            flags.command_present <= 1'b1;
            command_age           <= '0;
          end
        end
        vcw_pkg::MODE_LOC: begin
          flags.status_good    <= item.loc_ok;
          flags.status_present <= 1'b1;
          status_age           <= '0;
        end
        default: ;  // publish leaves state alone
      endcase
    end
  end

  // Held command triple; only read while command_present is set
  always_ff @(posedge clk) begin
    if (step && (item.mode == vcw_pkg::MODE_CMD)) begin
      if (item.cmd_invalid) begin
        held_vx <= '0;
        held_vy <= '0;
        held_wz <= '0;
      end else begin
        held_vx <= VEL_WIDTH'(item.lin_x);
        held_vy <= VEL_WIDTH'(item.lin_y);
        held_wz <= VEL_WIDTH'(item.ang_z);
      end
    end
  end

endmodule

/* sv/vcw_gate.sv */
// ----------------------------------------------------------------------------
// vcw_gate: safety decision and axis clamp
// Checks presence, health and staleness, then clamps each axis to +/- limit.
// ----------------------------------------------------------------------------
module vcw_gate #(
  parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF,
  parameter int AGE_WIDTH = vcw_pkg::AGE_WIDTH_DEF
) (
  input  vcw_pkg::cfg_t               regs,
  input  logic signed [VEL_WIDTH-1:0] held_vx,
  input  logic signed [VEL_WIDTH-1:0] held_vy,
  input  logic signed [VEL_WIDTH-1:0] held_wz,
  input  logic [AGE_WIDTH-1:0]        command_age,
  input  logic [AGE_WIDTH-1:0]        status_age,
  input  vcw_pkg::flags_t             flags,
  output vcw_pkg::rsp_t               result
);

  // Compare widths: CW fits both velocity and limit plus a sign bit; TW fits both age and timeout
  localparam int CW = ((VEL_WIDTH > vcw_pkg::LIMIT_W) ? VEL_WIDTH : vcw_pkg::LIMIT_W) + 1;
  localparam int TW = (AGE_WIDTH > vcw_pkg::TIMEOUT_W) ? AGE_WIDTH : vcw_pkg::TIMEOUT_W;

  function automatic logic signed [CW-1:0] clamp_sym(
    input logic signed [VEL_WIDTH-1:0]     v,
    input logic [vcw_pkg::LIMIT_W-1:0]     lim
  );
    logic signed [CW-1:0] vw;
    logic signed [CW-1:0] lw;
    vw = CW'(v);
    lw = $signed(CW'(lim));
    if (vw > lw) begin
      return lw;
    end else if (vw < -lw) begin
      return -lw;
    end
    return vw;
  endfunction

  logic cmd_stale;
  logic loc_stale;
  logic safe;
  logic signed [CW-1:0] clamp_vx;
  logic signed [CW-1:0] clamp_vy;
  logic signed [CW-1:0] clamp_wz;

  // Staleness only counts for a source that is present
  assign cmd_stale = flags.command_present &&
                     (TW'(command_age) > TW'(regs.cmd_timeout_ticks));
  assign loc_stale = flags.status_present &&
                     (TW'(status_age) > TW'(regs.loc_timeout_ticks));
  assign safe = flags.status_present && flags.status_good && flags.command_present &&
                !cmd_stale && !loc_stale;

  assign clamp_vx = clamp_sym(held_vx, regs.limit_vx);
  assign clamp_vy = clamp_sym(held_vy, regs.limit_vy);
  assign clamp_wz = clamp_sym(held_wz, regs.limit_wz);

  // Zeros are forced when unsafe
  always_comb begin
    result = '0;
    if (safe) begin
      result.out_vx  = vcw_pkg::vel_t'(clamp_vx);
      result.out_vy  = vcw_pkg::vel_t'(clamp_vy);
      result.out_wz  = vcw_pkg::vel_t'(clamp_wz);
      result.is_safe = 1'b1;
    end
  end

endmodule

/* sv/velocity_command_watchdog_top.sv */
// ----------------------------------------------------------------------------
// velocity_command_watchdog_top: safety gate for robot velocity commands
// Request register, watchdog state, gate logic and response register.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data): one event per transfer,
//   selected by mode: tick, command, localization status or publish request.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): one transfer per publish
//   request, holding the clamped command or zeros with is_safe low.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, taken in any cycle; cfg_ready is always high. Write only while
//   no event is in flight.
// Path: an event is captured in the request register and updates the state
//   from there; a publish result is formed by the gate from that state and
//   captured in the response register, which drives rsp.
// Throughput: one event per cycle while req_stall is low, through the state
//   update and gate path between the request and response registers.
// Stall: while rsp_stall holds a waiting result, a publish in the request
//   register waits and req_stall rises; a non-publish event there advances.
// Reset: clears the request and response valids, the flags and ages, and
//   returns the registers to their reset values.
// ----------------------------------------------------------------------------
module velocity_command_watchdog_top #(
  parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF,
  parameter int AGE_WIDTH = vcw_pkg::AGE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  vcw_pkg::req_t                   req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output vcw_pkg::rsp_t                   rsp_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                        item_valid;
  vcw_pkg::req_t               item;
  logic                        item_is_publish;
  logic                        rsp_free;
  logic                        item_adv;
  vcw_pkg::cfg_t               regs;
  vcw_pkg::flags_t             flags;
  vcw_pkg::rsp_t               result;
  logic signed [VEL_WIDTH-1:0] held_vx;
  logic signed [VEL_WIDTH-1:0] held_vy;
  logic signed [VEL_WIDTH-1:0] held_wz;
  logic [AGE_WIDTH-1:0]        command_age;
  logic [AGE_WIDTH-1:0]        status_age;

  // Handshake: a publish waits for room in the response register
  assign item_is_publish = (item.mode == vcw_pkg::MODE_PUBLISH);
  assign rsp_free        = !rsp_valid || !rsp_stall;
  assign item_adv        = item_valid && (!item_is_publish || rsp_free);
  assign req_stall       = item_valid && !item_adv;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      item <= req_data;
    end
  end

  vcw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  vcw_state #(
    .VEL_WIDTH (VEL_WIDTH),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (item_adv),
    .item        (item),
    .held_vx     (held_vx),
    .held_vy     (held_vy),
    .held_wz     (held_wz),
    .command_age (command_age),
    .status_age  (status_age),
    .flags       (flags)
  );

  vcw_gate #(
    .VEL_WIDTH (VEL_WIDTH),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_gate (
    .regs        (regs),
    .held_vx     (held_vx),
    .held_vy     (held_vy),
    .held_wz     (held_wz),
    .command_age (command_age),
    .status_age  (status_age),
    .flags       (flags),
    .result      (result)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (item_adv && item_is_publish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_adv && item_is_publish) begin
      rsp_data <= result;
    end
  end

endmodule

/* sv/vcw_checker.sv */
// ----------------------------------------------------------------------------
// vcw_checker: port-level checks for the velocity command watchdog
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module vcw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input vcw_pkg::req_t                   req_data,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input vcw_pkg::rsp_t                   rsp_data
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed or dropped");

  // A stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req_data))
    else $error("stalled request changed or dropped");

  // After reset the response register is empty and the request side does not stall
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("pipeline not empty after reset");

  // Forced-zero results carry no velocity
  a_unsafe_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.is_safe |->
      rsp_data.out_vx == '0 && rsp_data.out_vy == '0 && rsp_data.out_wz == '0)
    else $error("unsafe response with nonzero velocity");

  // The request side only waits while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a response stall");

endmodule

bind velocity_command_watchdog_top vcw_checker u_vcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

/* bench/tb_velocity_command_watchdog_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_velocity_command_watchdog_top: self-checking bench for the watchdog gate
// Feeds tick, command, localization and publish events through the request
// channel and predicts the held state, ages and clamped result in the bench.
// Every publish result is checked field by field. The run covers directed
// corners, random phases under several idle/stall mixes and limit settings,
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_velocity_command_watchdog_top;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_EVENTS  = 210;
  localparam int NUM_PHASES    = 8;

  logic                            clk;
  logic                            rst;
  logic                            req_valid;
  logic                            req_stall;
  vcw_pkg::req_t                   req_data;
  logic                            rsp_valid;
  logic                            rsp_stall;
  vcw_pkg::rsp_t                   rsp_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [vcw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [vcw_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Bench copy of the gate state and register set
  vcw_pkg::cfg_t                     gate_cfg;
  vcw_pkg::vel_t                     held_vx, held_vy, held_wz;
  logic [vcw_pkg::AGE_WIDTH_DEF-1:0] cmd_age, loc_age;
  vcw_pkg::flags_t                   held_flags;

  vcw_pkg::req_t event_q[$];
  vcw_pkg::rsp_t expected_gated_q[$];

  int events_sent;
  int events_taken;
  int results_checked;
  int mismatches;
  int cfg_writes;
  int cycle_cnt;
  int idle_pct;
  int stall_pct;

  // Receiver hold-off control
  logic hold_req;
  logic hold_active;
  logic hold_done;
  int   hold_cnt;

  velocity_command_watchdog_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Symmetric clamp of one axis to +/- lim
  function automatic vcw_pkg::vel_t clamp_axis(vcw_pkg::vel_t v,
                                               logic [vcw_pkg::LIMIT_W-1:0] lim);
    int lv;
    lv = int'(lim);
    if (int'(v) > lv) return vcw_pkg::vel_t'(lv);
    if (int'(v) < -lv) return vcw_pkg::vel_t'(-lv);
    return v;
  endfunction

  // Saturating age increment
  function automatic logic [vcw_pkg::AGE_WIDTH_DEF-1:0] age_step(
    logic [vcw_pkg::AGE_WIDTH_DEF-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  // Apply one accepted event to the bench state; publish yields a result
  task automatic watchdog_step(input vcw_pkg::req_t ev);
    vcw_pkg::rsp_t res;
    logic safe;
    case (ev.mode)
      vcw_pkg::MODE_TICK: begin
        cmd_age = age_step(cmd_age);
        loc_age = age_step(loc_age);
      end
      vcw_pkg::MODE_CMD: begin
        if (ev.cmd_invalid) begin
          // clear the held command, age stays
          held_flags.command_present = 1'b0;
          held_vx = '0;
          held_vy = '0;
          held_wz = '0;
        end else begin
          held_vx = ev.lin_x;
          held_vy = ev.lin_y;
          held_wz = ev.ang_z;
          cmd_age = '0;
          held_flags.command_present = 1'b1;
        end
      end
      vcw_pkg::MODE_LOC: begin
        held_flags.status_good    = ev.loc_ok;
        held_flags.status_present = 1'b1;
        loc_age = '0;
      end
      default: begin
        safe = held_flags.status_present && held_flags.status_good &&
               held_flags.command_present;
        if (held_flags.status_present && loc_age > gate_cfg.loc_timeout_ticks) safe = 1'b0;
        if (held_flags.command_present && cmd_age > gate_cfg.cmd_timeout_ticks) safe = 1'b0;
        res = '0;
        if (safe) begin
          res.out_vx  = clamp_axis(held_vx, gate_cfg.limit_vx);
          res.out_vy  = clamp_axis(held_vy, gate_cfg.limit_vy);
          res.out_wz  = clamp_axis(held_wz, gate_cfg.limit_wz);
          res.is_safe = 1'b1;
        end
        expected_gated_q.push_back(res);
      end
    endcase
  endtask

  // Event with every field random; the mode decides which fields matter
  function automatic vcw_pkg::req_t make_event(vcw_pkg::mode_t m);
    vcw_pkg::req_t ev;
    ev.mode        = m;
    ev.lin_x       = vcw_pkg::vel_t'($urandom);
    ev.lin_y       = vcw_pkg::vel_t'($urandom);
    ev.ang_z       = vcw_pkg::vel_t'($urandom);
    ev.cmd_invalid = 1'($urandom_range(0, 1));
    ev.loc_ok      = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Velocity biased toward the rails and the clamp boundary
  function automatic vcw_pkg::vel_t pick_vel(logic [vcw_pkg::LIMIT_W-1:0] lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      2, 3: begin
        v = int'(lim) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = int'($urandom);
    endcase
    return vcw_pkg::vel_t'(v);
  endfunction

  task automatic queue_event(input vcw_pkg::req_t ev);
    event_q.push_back(ev);
    events_sent++;
  endtask

  task automatic queue_mode(input vcw_pkg::mode_t m);
    queue_event(make_event(m));
  endtask

  task automatic queue_cmd(input vcw_pkg::vel_t x, input vcw_pkg::vel_t y,
                           input vcw_pkg::vel_t z, input logic inv);
    vcw_pkg::req_t ev;
    ev = make_event(vcw_pkg::MODE_CMD);
    ev.lin_x       = x;
    ev.lin_y       = y;
    ev.ang_z       = z;
    ev.cmd_invalid = inv;
    queue_event(ev);
  endtask

  task automatic queue_loc(input logic ok);
    vcw_pkg::req_t ev;
    ev = make_event(vcw_pkg::MODE_LOC);
    ev.loc_ok = ok;
    queue_event(ev);
  endtask

  // Mostly status/command/ticks/publish sequences, some lone random events
  task automatic queue_burst(output int n);
    int ticks;
    int pubs;
    n = 0;
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_loc($urandom_range(0, 9) != 0);
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        queue_cmd(pick_vel(gate_cfg.limit_vx), pick_vel(gate_cfg.limit_vy),
                  pick_vel(gate_cfg.limit_wz), $urandom_range(0, 9) == 0);
        n++;
      end
      ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 50) : $urandom_range(0, 6);
      repeat (ticks) queue_mode(vcw_pkg::MODE_TICK);
      pubs = $urandom_range(1, 2);
      repeat (pubs) queue_mode(vcw_pkg::MODE_PUBLISH);
      n += ticks + pubs;
    end else begin
      queue_mode(vcw_pkg::mode_t'($urandom_range(0, 3)));
      n++;
    end
  endtask

  // One register write transfer, then update the bench copy
  task automatic write_reg(input logic [vcw_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [vcw_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      vcw_pkg::REG_CMD_TIMEOUT: gate_cfg.cmd_timeout_ticks = val;
      vcw_pkg::REG_LOC_TIMEOUT: gate_cfg.loc_timeout_ticks = val;
      vcw_pkg::REG_LIMIT_VX:    gate_cfg.limit_vx = val[vcw_pkg::LIMIT_W-1:0];
      vcw_pkg::REG_LIMIT_VY:    gate_cfg.limit_vy = val[vcw_pkg::LIMIT_W-1:0];
      vcw_pkg::REG_LIMIT_WZ:    gate_cfg.limit_wz = val[vcw_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input logic [15:0] ct, input logic [15:0] lt,
                            input logic [15:0] lx, input logic [15:0] ly,
                            input logic [15:0] lz);
    write_reg(vcw_pkg::REG_CMD_TIMEOUT, ct);
    write_reg(vcw_pkg::REG_LOC_TIMEOUT, lt);
    write_reg(vcw_pkg::REG_LIMIT_VX, lx);
    write_reg(vcw_pkg::REG_LIMIT_VY, ly);
    write_reg(vcw_pkg::REG_LIMIT_WZ, lz);
  endtask

  // Idle/stall mix: none, sender idle, receiver stall, both light
  task automatic set_traffic(input int sel);
    case (sel)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 80; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 80; end
      default: begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  // Wait until every event is taken and every result is back, then let
  // the request register empty out
  task automatic wait_idle();
    while (events_taken != events_sent || expected_gated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: predict on each transfer, then offer the next event
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        watchdog_step(req_data);
        events_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req_data  <= event_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_cnt    <= 0;
    end else if (hold_active) begin
      if (hold_cnt == 1) begin
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
      end
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      hold_active <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
    end
  end

  // Response monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    vcw_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_gated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: vx=%0d vy=%0d wz=%0d safe=%b",
                   rsp_data.out_vx, rsp_data.out_vy, rsp_data.out_wz, rsp_data.is_safe);
      end else begin
        want = expected_gated_q.pop_front();
        results_checked++;
        if (rsp_data.out_vx !== want.out_vx || rsp_data.out_vy !== want.out_vy ||
            rsp_data.out_wz !== want.out_wz || rsp_data.is_safe !== want.is_safe) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: exp vx=%0d vy=%0d wz=%0d safe=%b, ",
                      "got vx=%0d vy=%0d wz=%0d safe=%b"},
                     results_checked, want.out_vx, want.out_vy, want.out_wz, want.is_safe,
                     rsp_data.out_vx, rsp_data.out_vy, rsp_data.out_wz, rsp_data.is_safe);
        end
      end
    end
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, expected_gated_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    int n;
    int count;
    rst             = 1'b1;
    req_valid       = 1'b0;
    req_data        = '0;
    rsp_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    hold_req        = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    events_sent     = 0;
    events_taken    = 0;
    results_checked = 0;
    mismatches      = 0;
    cfg_writes      = 0;
    gate_cfg   = '{vcw_pkg::CMD_TIMEOUT_RST, vcw_pkg::LOC_TIMEOUT_RST,
                   vcw_pkg::LIMIT_VX_RST, vcw_pkg::LIMIT_VY_RST, vcw_pkg::LIMIT_WZ_RST};
    held_vx    = '0;
    held_vy    = '0;
    held_wz    = '0;
    cmd_age    = '0;
    loc_age    = '0;
    held_flags = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset limits, rails, zero lateral limit
    set_traffic(0);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // nothing held
    queue_loc(1'b1);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // status only
    queue_cmd(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    queue_mode(vcw_pkg::MODE_PUBLISH);
    queue_cmd(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_mode(vcw_pkg::MODE_PUBLISH);
    wait_idle();

    // Directed: short timeouts, full and zero limits
    set_config(16'd2, 16'd1, 16'd32767, 16'd32767, 16'd0);
    queue_cmd(16'h8000, 16'h7FFF, 16'h1234, 1'b0);
    queue_loc(1'b1);
    queue_mode(vcw_pkg::MODE_PUBLISH);
    queue_mode(vcw_pkg::MODE_TICK);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // status age at its timeout
    queue_mode(vcw_pkg::MODE_TICK);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // status stale
    queue_loc(1'b1);
    queue_mode(vcw_pkg::MODE_PUBLISH);
    queue_mode(vcw_pkg::MODE_TICK);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // command stale
    queue_cmd(vcw_pkg::vel_t'($urandom), vcw_pkg::vel_t'($urandom),
              vcw_pkg::vel_t'($urandom), 1'b1);
    queue_loc(1'b1);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // command cleared
    queue_cmd(16'd1, 16'd2, 16'd3, 1'b0);
    queue_loc(1'b0);
    queue_mode(vcw_pkg::MODE_PUBLISH);        // status unhealthy
    queue_loc(1'b1);
    queue_mode(vcw_pkg::MODE_TICK);
    queue_mode(vcw_pkg::MODE_PUBLISH);
    wait_idle();

    // Random phases over limit settings and idle/stall mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(16'd10, 16'd15, 16'd4096, 16'd4096, 16'd4096);
        1: set_config(16'd0, 16'd0, 16'd32767, 16'd32767, 16'd32767);
        2: set_config(16'd65534, 16'd65534, 16'd0, 16'd0, 16'd0);
        default: set_config(16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                            16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                            16'($urandom_range(0, 32767)));
      endcase
      set_traffic(p % 4);
      count = 0;
      while (count < PHASE_EVENTS) begin
        queue_burst(n);
        count += n;
      end
      wait_idle();
    end

    // Receiver holds off while publishes keep coming, so the input backs up
    set_config(16'd1000, 16'd1000, 16'd2048, 16'd1024, 16'd512);
    set_traffic(0);
    @(posedge clk);
    hold_req <= 1'b1;
    queue_loc(1'b1);
    queue_cmd(pick_vel(15'd2048), pick_vel(15'd1024), pick_vel(15'd512), 1'b0);
    repeat (60) queue_mode(vcw_pkg::MODE_PUBLISH);
    while (!hold_done) @(posedge clk);
    wait_idle();

    $display("covered %0d events: directed corners, %0d random phases, hold-off",
             events_taken, NUM_PHASES);
    $display("%0d results checked, %0d register writes, %0d cycles, %0d mismatches",
             results_checked, cfg_writes, cycle_cnt, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
